@@ rtl/scpc_pkg.sv @@
package scpc_pkg;

  localparam int FIELD_W        = 16;
  localparam int TOTAL_W        = 17;
  localparam int CROSS_W        = 16;
  localparam int DEF_MAX_SEGS   = 256;
  localparam int DEF_COORD_BITS = 16;
  localparam int UPC_W          = 4;

  localparam logic [CROSS_W-1:0] CROSS_MAX = {CROSS_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    M_NONE,
    M_MUL,
    M_MSUB
  } mop_t;

  typedef enum logic [1:0] {
    D_DEN,
    D_TN,
    D_UN
  } dst_t;

  typedef enum logic [2:0] {
    OP_DX12,
    OP_DY12,
    OP_DX34,
    OP_DY34,
    OP_DX13,
    OP_DY13
  } opsel_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_FEW,
    J_MORE,
    J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic             rd_en;
    logic             diff_en;
    mop_t             mop;
    dst_t             dst;
    opsel_t           sel_a;
    opsel_t           sel_b;
    logic             test;
    logic             emit;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam uword_t UWORD_NOP = '{
    rd_en: 1'b0, diff_en: 1'b0, mop: M_NONE, dst: D_DEN, sel_a: OP_DX12,
    sel_b: OP_DX12, test: 1'b0, emit: 1'b0, jmp: J_NEXT, target: '0
  };

  typedef struct packed {
    logic few;
    logic more;
    logic out_free;
  } seq_stat_t;

endpackage

@@ rtl/scpc_if.sv @@
interface scpc_in_if;
  import scpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_start;
  logic signed [FIELD_W-1:0] y_start;
  logic signed [FIELD_W-1:0] x_end;
  logic signed [FIELD_W-1:0] y_end;
  logic                      last_segment;

  modport source (output valid, x_start, y_start, x_end, y_end, last_segment, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, last_segment, output ready);
endinterface

interface scpc_out_if;
  import scpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] pieces_total;

  modport source (output valid, pieces_total, input ready);
  modport sink   (input valid, pieces_total, output ready);
endinterface

@@ rtl/scpc_store.sv @@
module scpc_store #(
  parameter int DEPTH   = 256,
  parameter int ENTRY_W = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [ENTRY_W-1:0]       rd_data_a,
  output logic [ENTRY_W-1:0]       rd_data_b
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/scpc_useq.sv @@
module scpc_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  scpc_pkg::seq_stat_t stat,
  output logic                busy,
  output scpc_pkg::uword_t    ctl
);
  import scpc_pkg::*;

  localparam logic [UPC_W-1:0] UPC_START = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_FETCH = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_DONE  = UPC_W'(10);

  // One pair per pass over FETCH..TEST; den, tn, un share one multiplier.
  function automatic uword_t rom(input logic [UPC_W-1:0] a);
    uword_t w;
    w = UWORD_NOP;
    case (a)
      4'd0: begin
        w.jmp = J_FEW;  w.target = UPC_DONE;
      end
      4'd1: w.rd_en = 1'b1;
      4'd2: w.diff_en = 1'b1;
      4'd3: begin
        w.mop = M_MUL;  w.sel_a = OP_DX12; w.sel_b = OP_DY34;
      end
      4'd4: begin
        w.mop = M_MSUB; w.dst = D_DEN; w.sel_a = OP_DY12; w.sel_b = OP_DX34;
      end
      4'd5: begin
        w.mop = M_MUL;  w.sel_a = OP_DX13; w.sel_b = OP_DY34;
      end
      4'd6: begin
        w.mop = M_MSUB; w.dst = D_TN; w.sel_a = OP_DY13; w.sel_b = OP_DX34;
      end
      4'd7: begin
        w.mop = M_MUL;  w.sel_a = OP_DX13; w.sel_b = OP_DY12;
      end
      4'd8: begin
        w.mop = M_MSUB; w.dst = D_UN; w.sel_a = OP_DY13; w.sel_b = OP_DX12;
      end
      4'd9: begin
        w.test = 1'b1;  w.jmp = J_MORE; w.target = UPC_FETCH;
      end
      4'd10: begin
        w.emit = 1'b1;  w.jmp = J_WAIT_OUT;
      end
      default: w = UWORD_NOP;
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             busy_r, busy_nxt;
  uword_t           word;

  assign word = rom(upc_r);
  assign ctl  = busy_r ? word : UWORD_NOP;
  assign busy = busy_r;

  always_comb begin
    upc_nxt  = upc_r + UPC_W'(1);
    busy_nxt = busy_r;
    case (word.jmp)
      J_NEXT: ;
      J_FEW: begin
        if (stat.few) upc_nxt = word.target;
      end
      J_MORE: begin
        if (stat.more) upc_nxt = word.target;
      end
      J_WAIT_OUT: begin
        if (stat.out_free) begin
          busy_nxt = 1'b0;
          upc_nxt  = UPC_START;
        end else begin
          upc_nxt = upc_r;
        end
      end
      default: upc_nxt = UPC_START;
    endcase
    if (!busy_r) begin
      upc_nxt  = UPC_START;
      busy_nxt = start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= UPC_START;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ rtl/scpc_datapath.sv @@
module scpc_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  scpc_pkg::uword_t        ctl,
  input  logic [4*COORD_BITS-1:0] seg_p,
  input  logic [4*COORD_BITS-1:0] seg_q,
  output logic                    hit
);
  import scpc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [C-1:0] p_xs, p_ys, p_xe, p_ye;
  logic signed [C-1:0] q_xs, q_ys, q_xe, q_ye;

  assign {p_xs, p_ys, p_xe, p_ye} = seg_p;
  assign {q_xs, q_ys, q_xe, q_ye} = seg_q;

  logic signed [DW-1:0] dx12_r, dy12_r, dx34_r, dy34_r, dx13_r, dy13_r;

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      dx12_r <= DW'(p_xs) - DW'(p_xe);
      dy12_r <= DW'(p_ys) - DW'(p_ye);
      dx34_r <= DW'(q_xs) - DW'(q_xe);
      dy34_r <= DW'(q_ys) - DW'(q_ye);
      dx13_r <= DW'(p_xs) - DW'(q_xs);
      dy13_r <= DW'(p_ys) - DW'(q_ys);
    end
  end

  function automatic logic signed [DW-1:0] pick(input opsel_t s,
      input logic signed [DW-1:0] dx12, dy12, dx34, dy34, dx13, dy13);
    logic signed [DW-1:0] v;
    case (s)
      OP_DX12: v = dx12;
      OP_DY12: v = dy12;
      OP_DX34: v = dx34;
      OP_DY34: v = dy34;
      OP_DX13: v = dx13;
      OP_DY13: v = dy13;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] tmp_r;
  logic signed [NW-1:0] diff;
  logic signed [NW-1:0] den_r, tn_r, un_r;

  assign mul_a = pick(ctl.sel_a, dx12_r, dy12_r, dx34_r, dy34_r, dx13_r, dy13_r);
  assign mul_b = pick(ctl.sel_b, dx12_r, dy12_r, dx34_r, dy34_r, dx13_r, dy13_r);
  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign diff  = NW'(tmp_r) - NW'(prod);

  always_ff @(posedge clk) begin
    case (ctl.mop)
      M_NONE: ;
      M_MUL:  tmp_r <= prod;
      M_MSUB: begin
        case (ctl.dst)
          D_DEN:   den_r <= diff;
          D_TN:    tn_r  <= diff;
          D_UN:    un_r  <= diff;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // parameter in [0,1]: 0 <= n <= d for d > 0, d <= n <= 0 for d < 0
  function automatic logic within_unit(input logic signed [NW-1:0] n,
                                       input logic signed [NW-1:0] d);
    logic r;
    if (d > 0) r = (n >= 0) && (n <= d);
    else       r = (n <= 0) && (n >= d);
    return r;
  endfunction

  assign hit = (den_r != '0) && within_unit(tn_r, den_r) && within_unit(un_r, den_r);

endmodule

@@ rtl/segment_crossing_piece_count_unit.sv @@
// Channel   Dir  Payload                                      Accepted when
// in_seg    in   x_start y_start x_end y_end last_segment     valid && ready
// out_res   out  pieces_total                                 valid && ready
//
// Loading accepts one segment per cycle while idle. After the last_segment
// transaction the microcode sequencer runs fetch, difference, six steps on
// the single multiplier and test for each of the n(n-1)/2 pairs, plus a setup
// step and a result hand-off step; in_seg.ready stays low for that time.
// Reset clears the counts and the sequencer; the segment store holds no reset
// state. A stalled out_res holds the sequencer in its final step.
module segment_crossing_piece_count_unit #(
  parameter int MAX_SEGMENTS = scpc_pkg::DEF_MAX_SEGS,
  parameter int COORD_BITS   = scpc_pkg::DEF_COORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  scpc_in_if.sink    in_seg,
  scpc_out_if.source out_res
);
  import scpc_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int ENTRY_W = 4 * C;
  localparam int AW      = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int IW      = CNT_W + 1;
  localparam int EXT_W   = (C > FIELD_W) ? C : FIELD_W;
  localparam int SUM_W   = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;

  logic             busy;
  uword_t           ctl;
  seq_stat_t        stat;
  logic             hit;
  logic             in_fire, out_fire, start;
  logic [CNT_W-1:0] count_r;
  logic [AW-1:0]    a_r, b_r;
  logic [CROSS_W-1:0] cross_r;
  logic             out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic             full;
  logic [EXT_W-1:0] xs_ext, ys_ext, xe_ext, ye_ext;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] seg_p, seg_q;
  logic [IW-1:0]    b_inc, a_inc2;
  logic [SUM_W-1:0] sum;

  assign in_seg.ready  = !busy;
  assign in_fire       = in_seg.valid && in_seg.ready;
  assign start         = in_fire && in_seg.last_segment;
  assign out_fire      = out_res.valid && out_res.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.pieces_total = out_total_r;

  assign full = (count_r == CNT_W'(MAX_SEGMENTS));

  // coordinate is the low COORD_BITS of the field pattern, two's complement
  assign xs_ext = EXT_W'($unsigned(in_seg.x_start));
  assign ys_ext = EXT_W'($unsigned(in_seg.y_start));
  assign xe_ext = EXT_W'($unsigned(in_seg.x_end));
  assign ye_ext = EXT_W'($unsigned(in_seg.y_end));
  assign wr_data = {xs_ext[C-1:0], ys_ext[C-1:0], xe_ext[C-1:0], ye_ext[C-1:0]};

  scpc_store #(
    .DEPTH   (MAX_SEGMENTS),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_fire && !full),
    .wr_addr   (count_r[AW-1:0]),
    .wr_data   (wr_data),
    .rd_en     (ctl.rd_en),
    .rd_addr_a (a_r),
    .rd_addr_b (b_r),
    .rd_data_a (seg_p),
    .rd_data_b (seg_q)
  );

  assign b_inc  = IW'(b_r) + IW'(1);
  assign a_inc2 = IW'(a_r) + IW'(2);

  assign stat.few      = (count_r < CNT_W'(2));
  assign stat.more     = (b_inc < IW'(count_r)) || (a_inc2 < IW'(count_r));
  assign stat.out_free = !out_valid_r || out_res.ready;

  scpc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  scpc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk   (clk),
    .ctl   (ctl),
    .seg_p (seg_p),
    .seg_q (seg_q),
    .hit   (hit)
  );

  assign sum = SUM_W'(count_r) + (SUM_W'(cross_r) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cross_r     <= '0;
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (start) begin
        a_r <= '0;
        b_r <= AW'(1);
      end
      if (ctl.test) begin
        if (hit && cross_r != CROSS_MAX) begin
          cross_r <= cross_r + CROSS_W'(1);
        end
        if (b_inc < IW'(count_r)) begin
          b_r <= b_inc[AW-1:0];
        end else begin
          a_r <= a_r + AW'(1);
          b_r <= a_inc2[AW-1:0];
        end
      end
      if (ctl.emit && stat.out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        cross_r     <= '0;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && stat.out_free) begin
      out_total_r <= (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
  end

endmodule
